// ===== src/can_frame_bundler_macros.svh =====
// Assertion macros for the CAN frame bundler.
`ifndef CAN_FRAME_BUNDLER_MACROS_SVH
`define CAN_FRAME_BUNDLER_MACROS_SVH
`ifndef SYNTHESIS
`define CFB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define CFB_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define CFB_ASSERT(label, prop, msg)
`define CFB_NEVER(label, cond, msg)
`endif
`endif

// ===== src/cfb_pkg.sv =====
// Shared types and constants for the CAN frame bundler.
package cfb_pkg;
    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_SLOT  = 2'd1;
    localparam logic [1:0] KIND_SET   = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;
    localparam logic [1:0] MODE_ALL    = 2'd0;
    localparam logic [1:0] MODE_TIMED  = 2'd1;
    localparam logic [1:0] MODE_SAMPLE = 2'd2;
    localparam logic [1:0] MODE_OFF    = 2'd3;
    localparam int US_PER_MS = 1000;
    localparam logic [31:0] GAP_RESET = 32'd1000;
    localparam int IN_W  = 2+2+3+29+1+2+16+8+8+4+64+48;
    localparam int OUT_W = 2+8+8+48+29+4+64;
endpackage

// ===== src/can_frame_bundler.sv =====
// Top level of the CAN frame bundler: sequencer, slot tables and output register.
// Usage:
//  s_axis carries one command per transfer: a frame (kind 0), a slot identifier
//  write (kind 1) or a bundler settings write (kind 2). m_axis carries one
//  stored frame per transfer; tuser[0] marks the last frame of a bundle and
//  tlast the last result caused by the command.
//  i_cfg_we/i_cfg_wdata write the gap timeout in microseconds (reset 1000).
// Sequencing:
//  a command is taken, then one shared sequencer visits the bundlers one at a
//  time. An active bundler walks its slots through the identifier compare,
//  then multiplies the window, decides and steps on; one with no matching slot
//  skips the decide step, and an inactive one steps on directly. A bundler that
//  emits walks its slots again and waits there while the output register is full.
//  A frame holds the sequencer until every bundler is visited and the last
//  result is in the output register, longer when bundlers emit or the receiver
//  stalls; tready is low meanwhile. Settings and slot writes are done in idle.
//  Time comparisons go through one shared 48-bit subtract/compare unit.
// Reset clears all tables but payload and length, and sets all bundlers
// inactive. When the receiver stalls, the sequencer holds on the output
// register until the frame is taken; nothing is dropped.
module can_frame_bundler
    import cfb_pkg::*;
#(
    parameter int NUM_BUNDLERS      = 4,
    parameter int SLOTS_PER_BUNDLER = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // kind, bundler_index, slot_index, can_id, slot_enable, mode, window_ms,
    // source_tag, type_tag, frame_length, frame_payload, arrival_us, 5'b0
    input  logic [191:0]      s_axis_tdata,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_wdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // out_bundler, out_source, out_type, bundle_time_us, out_id, out_length,
    // out_payload, 5'b0
    output logic [167:0]      m_axis_tdata,
    // bundle_end
    output logic              m_axis_tuser,
    output logic              m_axis_tlast
);
    localparam int NB = NUM_BUNDLERS;
    localparam int NS = SLOTS_PER_BUNDLER;
    localparam int BW = (NB > 1) ? $clog2(NB) : 1;
    localparam int SW = (NS > 1) ? $clog2(NS) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DEC  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;
    localparam logic [2:0] ST_NEXT = 3'd5;
    localparam logic [2:0] ST_WAIT = 3'd6;

    // unpack input
    logic [1:0]  in_kind, in_bi, in_mode;
    logic [2:0]  in_si;
    logic [28:0] in_id;
    logic        in_en;
    logic [15:0] in_win;
    logic [7:0]  in_src, in_typ;
    logic [3:0]  in_len;
    logic [63:0] in_pay;
    logic [47:0] in_time;
    assign in_kind = s_axis_tdata[1:0];
    assign in_bi   = s_axis_tdata[3:2];
    assign in_si   = s_axis_tdata[6:4];
    assign in_id   = s_axis_tdata[35:7];
    assign in_en   = s_axis_tdata[36];
    assign in_mode = s_axis_tdata[38:37];
    assign in_win  = s_axis_tdata[54:39];
    assign in_src  = s_axis_tdata[62:55];
    assign in_typ  = s_axis_tdata[70:63];
    assign in_len  = s_axis_tdata[74:71];
    assign in_pay  = s_axis_tdata[138:75];
    assign in_time = s_axis_tdata[186:139];

    logic [31:0] r_gap;
    logic [28:0] r_ids  [NB][NS];
    logic [NS-1:0] r_use [NB];
    logic [NS-1:0] r_rcv [NB];
    logic [63:0] r_pay  [NB][NS];
    logic [3:0]  r_len  [NB][NS];
    logic [1:0]  r_mode [NB];
    logic [15:0] r_win  [NB];
    logic [7:0]  r_src  [NB];
    logic [7:0]  r_typ  [NB];
    logic [47:0] r_start[NB];
    logic [NB-1:0] r_started;

    logic [2:0]  r_st;
    logic [BW-1:0] r_b;
    logic [SW:0] r_s;
    logic [NS-1:0] r_hitv;
    logic [28:0] r_id;
    logic [3:0]  r_flen;
    logic [63:0] r_fpay;
    logic [47:0] r_now;
    logic [47:0] r_lim;
    logic        r_any;   // any result emitted this command
    logic        r_clr;   // clear slots at bundle end (not sample)
    logic        r_ov, r_ob, r_ol;
    logic [167:0] r_od;

    // shared compare unit: now > since && now - since > limit
    logic [47:0] cu_since, cu_diff;
    logic        cu_gt;
    assign cu_since = r_start[r_b];
    assign cu_diff  = r_now - cu_since;
    assign cu_gt    = (r_now > cu_since) && (cu_diff > r_lim);

    logic [SW-1:0] s_ix;
    assign s_ix = r_s[SW-1:0];

    // later received slot in use after s_ix?
    logic more;
    always_comb begin
        more = 1'b0;
        for (int k = 0; k < NS; k++)
            if (k > int'(s_ix) && r_use[r_b][k] && r_rcv[r_b][k]) more = 1'b1;
    end

    // any later bundler that could still emit is unknown; tlast is decided by
    // holding the last result until the next one or the end of the command.
    logic [BW:0] b_next;
    assign b_next = {1'b0, r_b} + 1'b1;
    logic last_b;
    assign last_b = (b_next == (BW+1)'(NB));

    logic r_hv; // a result is held back pending tlast decision
    logic [167:0] r_hd;
    logic r_hu;

    assign s_axis_tready = (r_st == ST_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;
    assign m_axis_tuser  = r_ob;
    assign m_axis_tlast  = r_ol;

    logic out_free;
    assign out_free = !r_ov || m_axis_tready;

    // emit walk sits on a stored slot; held result moves to the output register
    logic emit_slot, load_out;
    assign emit_slot = (r_st == ST_EMIT) && (r_s != (SW+1)'(NS)) &&
                       r_use[r_b][s_ix] && r_rcv[r_b][s_ix];
    assign load_out  = out_free && ((emit_slot && r_hv) || (r_st == ST_WAIT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= GAP_RESET;
            r_st <= ST_IDLE;
            r_ov <= 1'b0;
            r_hv <= 1'b0;
            r_started <= '0;
            for (int b = 0; b < NB; b++) begin
                r_use[b] <= '0; r_rcv[b] <= '0; r_mode[b] <= MODE_OFF;
                r_win[b] <= '0; r_src[b] <= '0; r_typ[b] <= '0; r_start[b] <= '0;
                for (int s = 0; s < NS; s++) r_ids[b][s] <= '0;
            end
        end else begin
            if (i_cfg_we) r_gap <= i_cfg_wdata;
            if (r_ov && m_axis_tready && !load_out) r_ov <= 1'b0;
            case (r_st)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_id <= in_id; r_flen <= in_len; r_fpay <= in_pay;
                        r_now <= in_time; r_b <= '0; r_s <= '0; r_hitv <= '0;
                        r_any <= 1'b0;
                        if (in_kind == KIND_SLOT) begin
                            if (int'(in_bi) < NB && int'(in_si) < NS) begin
                                r_ids[in_bi[BW-1:0]][in_si[SW-1:0]] <= in_id;
                                r_use[in_bi[BW-1:0]][in_si[SW-1:0]] <= in_en;
                                r_rcv[in_bi[BW-1:0]][in_si[SW-1:0]] <= 1'b0;
                            end
                        end else if (in_kind == KIND_SET) begin
                            if (int'(in_bi) < NB) begin
                                r_mode[in_bi[BW-1:0]] <= in_mode;
                                r_win[in_bi[BW-1:0]] <= in_win;
                                r_src[in_bi[BW-1:0]] <= in_src;
                                r_typ[in_bi[BW-1:0]] <= in_typ;
                                r_started[in_bi[BW-1:0]] <= 1'b0;
                                r_start[in_bi[BW-1:0]] <= '0;
                                r_rcv[in_bi[BW-1:0]] <= '0;
                            end
                        end else if (in_kind == KIND_FRAME) begin
                            r_st <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    // one slot per cycle through the identifier compare
                    if (r_mode[r_b] == MODE_OFF) begin
                        r_st <= ST_NEXT;
                    end else begin
                        r_hitv[s_ix] <= r_use[r_b][s_ix] && (r_ids[r_b][s_ix] == r_id);
                        if (r_s == (SW+1)'(NS-1)) r_st <= ST_MUL;
                        r_s <= r_s + 1'b1;
                    end
                    r_lim <= {16'd0, r_gap};
                end
                ST_MUL: begin
                    if (r_hitv == '0) begin
                        r_st <= ST_NEXT;
                    end else begin
                        // gap check in all-received mode uses r_lim = gap
                        if (r_mode[r_b] == MODE_ALL) begin
                            if (r_started[r_b] && cu_gt) r_rcv[r_b] <= r_hitv;
                            else r_rcv[r_b] <= r_rcv[r_b] | r_hitv;
                        end else begin
                            r_rcv[r_b] <= r_rcv[r_b] | r_hitv;
                        end
                        for (int s = 0; s < NS; s++)
                            if (r_hitv[s]) begin
                                r_pay[r_b][s] <= r_fpay;
                                r_len[r_b][s] <= r_flen;
                            end
                        r_lim <= 48'(r_win[r_b] * 26'(US_PER_MS));
                        r_st <= ST_DEC;
                    end
                end
                ST_DEC: begin
                    r_s <= '0;
                    r_clr <= (r_mode[r_b] != MODE_SAMPLE);
                    if (r_mode[r_b] == MODE_ALL) begin
                        r_start[r_b] <= r_now;
                        r_started[r_b] <= 1'b1;
                        r_st <= ((r_use[r_b] & ~r_rcv[r_b]) == '0) ? ST_EMIT : ST_NEXT;
                    end else if (!r_started[r_b]) begin
                        r_start[r_b] <= r_now;
                        r_started[r_b] <= 1'b1;
                        r_st <= ST_NEXT;
                    end else begin
                        r_st <= cu_gt ? ST_EMIT : ST_NEXT;
                    end
                end
                ST_EMIT: begin
                    if (r_s == (SW+1)'(NS)) begin
                        if (r_clr) begin
                            r_rcv[r_b] <= '0;
                            r_started[r_b] <= 1'b0;
                            r_start[r_b] <= '0;
                        end else begin
                            r_start[r_b] <= r_now;
                        end
                        r_st <= ST_NEXT;
                    end else if (!(r_use[r_b][s_ix] && r_rcv[r_b][s_ix])) begin
                        r_s <= r_s + 1'b1;
                    end else if (!r_hv || out_free) begin
                        if (r_hv) begin
                            r_ov <= 1'b1; r_od <= r_hd; r_ob <= r_hu; r_ol <= 1'b0;
                        end
                        r_hv <= 1'b1;
                        r_hu <= !more;
                        r_any <= 1'b1;
                        r_hd <= {5'b0, r_pay[r_b][s_ix], r_len[r_b][s_ix],
                                 r_ids[r_b][s_ix], r_start[r_b], r_typ[r_b],
                                 r_src[r_b], 2'(r_b)};
                        r_s <= r_s + 1'b1;
                    end
                end
                ST_NEXT: begin
                    r_s <= '0; r_hitv <= '0;
                    if (last_b) r_st <= r_hv ? ST_WAIT : ST_IDLE;
                    else begin
                        r_b <= b_next[BW-1:0];
                        r_st <= ST_SCAN;
                    end
                end
                ST_WAIT: begin
                    if (out_free) begin
                        r_ov <= 1'b1; r_od <= r_hd; r_ob <= r_hu; r_ol <= 1'b1;
                        r_hv <= 1'b0;
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

`include "can_frame_bundler_macros.svh"
    `CFB_ASSERT(a_busy, (r_st != ST_IDLE) |-> !s_axis_tready, "ready while busy")
    `CFB_ASSERT(a_hold, (r_ov && !m_axis_tready) |=> (r_ov && $stable(r_od)), "output moved")
    `CFB_NEVER(a_wait, (r_st == ST_WAIT) && !r_hv, "wait without held result")
    `CFB_ASSERT(a_any, r_hv |-> (r_any || r_st == ST_IDLE), "held result without emission")
endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for can_frame_bundler: stream driver, monitor and bundle predictor.
`timescale 1ns / 1ps

module testbench;
    import cfb_pkg::*;

    localparam int NB = 4;
    localparam int NS = 8;
    localparam int SETTLE = 200;       // idle cycles that cover one command's latency
    localparam int STALL_LIMIT = 5000; // cycles with no transfer before giving up

    typedef struct {
        logic [1:0]  kind;
        logic [1:0]  bidx;
        logic [2:0]  sidx;
        logic [28:0] id;
        logic        en;
        logic [1:0]  mode;
        logic [15:0] win;
        logic [7:0]  src;
        logic [7:0]  typ;
        logic [3:0]  len;
        logic [63:0] payload;
        logic [47:0] t;
    } cmd_t;

    typedef struct {
        logic [1:0]  bundler;
        logic [7:0]  src;
        logic [7:0]  typ;
        logic [47:0] btime;
        logic [28:0] id;
        logic [3:0]  len;
        logic [63:0] payload;
        logic        bend;
        logic        rlast;
    } frame_out_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata = '0;
    logic         i_cfg_we = 1'b0;
    logic [31:0]  i_cfg_wdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [167:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;

    can_frame_bundler #(.NUM_BUNDLERS(NB), .SLOTS_PER_BUNDLER(NS)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------- predictor state ----------------
    logic [31:0] gap_us;
    logic [28:0] tbl_id   [NB*NS];
    logic        tbl_used [NB*NS];
    logic        tbl_rx   [NB*NS];
    logic [63:0] tbl_pay  [NB*NS];
    logic [3:0]  tbl_len  [NB*NS];
    logic [1:0]  b_mode   [NB];
    logic [15:0] b_win    [NB];
    logic [7:0]  b_src    [NB];
    logic [7:0]  b_typ    [NB];
    logic [47:0] b_start  [NB];
    logic        b_run    [NB];

    cmd_t       pending_cmds[$];
    frame_out_t bundle_queue[$];
    int         errors = 0;
    bit         quiet = 0;        // phase without any idling on either side

    function automatic bit past_limit(logic [47:0] now, logic [47:0] since,
                                      logic [63:0] limit);
        return now > since && 64'(now - since) > limit;
    endfunction

    function automatic void drop_bundle(int b);
        for (int s = 0; s < NS; s++) tbl_rx[b*NS+s] = 1'b0;
    endfunction

    // Work out every stored frame one accepted command releases.
    function automatic void predict_bundles(cmd_t c);
        frame_out_t run[$];
        frame_out_t r;
        bit hit, done;
        int k, last;
        if (c.kind == KIND_SLOT) begin
            k = c.bidx*NS + c.sidx;
            tbl_id[k] = c.id; tbl_used[k] = c.en; tbl_rx[k] = 1'b0;
            return;
        end
        if (c.kind == KIND_SET) begin
            b_mode[c.bidx] = c.mode; b_win[c.bidx] = c.win;
            b_src[c.bidx] = c.src; b_typ[c.bidx] = c.typ;
            b_run[c.bidx] = 1'b0; b_start[c.bidx] = '0;
            drop_bundle(c.bidx);
            return;
        end
        if (c.kind != KIND_FRAME) return;  // kind three is ignored
        for (int b = 0; b < NB; b++) begin
            hit = 0; done = 0;
            if (b_mode[b] == MODE_OFF) continue;
            for (int s = 0; s < NS; s++)
                if (tbl_used[b*NS+s] && tbl_id[b*NS+s] == c.id) hit = 1;
            if (!hit) continue;
            // all-received bundle goes stale when frames are too far apart
            if (b_mode[b] == MODE_ALL && b_run[b] && past_limit(c.t, b_start[b], 64'(gap_us)))
                drop_bundle(b);
            for (int s = 0; s < NS; s++) begin
                k = b*NS + s;
                if (tbl_used[k] && tbl_id[k] == c.id) begin
                    tbl_pay[k] = c.payload; tbl_len[k] = c.len; tbl_rx[k] = 1'b1;
                end
            end
            if (b_mode[b] == MODE_ALL) begin
                b_start[b] = c.t; b_run[b] = 1'b1; done = 1;
                for (int s = 0; s < NS; s++)
                    if (tbl_used[b*NS+s] && !tbl_rx[b*NS+s]) done = 0;
            end else if (!b_run[b]) begin
                b_start[b] = c.t; b_run[b] = 1'b1;
            end else begin
                done = past_limit(c.t, b_start[b], 64'(b_win[b]) * US_PER_MS);
            end
            if (done) begin
                last = -1;
                for (int s = 0; s < NS; s++) begin
                    k = b*NS + s;
                    if (!tbl_used[k] || !tbl_rx[k] || run.size() >= 32) continue;
                    r.bundler = b[1:0]; r.src = b_src[b]; r.typ = b_typ[b];
                    r.btime = b_start[b]; r.id = tbl_id[k]; r.len = tbl_len[k];
                    r.payload = tbl_pay[k]; r.bend = 0; r.rlast = 0;
                    run = {run, r};
                    last = run.size() - 1;
                end
                if (last >= 0) run[last].bend = 1;
                if (b_mode[b] == MODE_SAMPLE) b_start[b] = c.t;
                else begin
                    drop_bundle(b); b_run[b] = 1'b0; b_start[b] = '0;
                end
            end
        end
        if (run.size() > 0) run[run.size()-1].rlast = 1;
        bundle_queue = {bundle_queue, run};
    endfunction

    function automatic logic [191:0] pack_cmd(cmd_t c);
        return {5'b0, c.t, c.payload, c.len, c.typ, c.src, c.win, c.mode, c.en,
                c.id, c.sidx, c.bidx, c.kind};
    endfunction

    function automatic int draw_wait();
        return quiet ? 0 : $urandom_range(0, 14);
    endfunction

    // ---------------- monitor: sample at rising edge ----------------
    logic took_in = 0, took_out = 0;
    cmd_t driven_cmd;
    int   idle_cycles = 0;

    always @(posedge i_clk) begin
        frame_out_t e;
        logic [1:0]  a_b;
        logic [7:0]  a_src, a_typ;
        logic [47:0] a_t;
        logic [28:0] a_id;
        logic [3:0]  a_len;
        logic [63:0] a_pay;
        took_in  <= i_rst_n && s_axis_tvalid && s_axis_tready;
        took_out <= i_rst_n && m_axis_tvalid && m_axis_tready;
        if (i_rst_n) begin
            // output first: a result never belongs to a command taken on this edge
            if (m_axis_tvalid && m_axis_tready) begin
                {a_pay, a_len, a_id, a_t, a_typ, a_src, a_b} = m_axis_tdata[162:0];
                if (bundle_queue.size() == 0) begin
                    $error("unexpected output transfer id=%h", a_id);
                    errors++;
                end else begin
                    e = bundle_queue.pop_front();
                    if (a_b !== e.bundler) begin
                        $error("out_bundler exp %h got %h", e.bundler, a_b); errors++;
                    end
                    if (a_src !== e.src) begin
                        $error("out_source exp %h got %h", e.src, a_src); errors++;
                    end
                    if (a_typ !== e.typ) begin
                        $error("out_type exp %h got %h", e.typ, a_typ); errors++;
                    end
                    if (a_t !== e.btime) begin
                        $error("bundle_time_us exp %h got %h", e.btime, a_t); errors++;
                    end
                    if (a_id !== e.id) begin
                        $error("out_id exp %h got %h", e.id, a_id); errors++;
                    end
                    if (a_len !== e.len) begin
                        $error("out_length exp %h got %h", e.len, a_len); errors++;
                    end
                    if (a_pay !== e.payload) begin
                        $error("out_payload exp %h got %h", e.payload, a_pay); errors++;
                    end
                    if (m_axis_tuser !== e.bend) begin
                        $error("bundle_end exp %b got %b", e.bend, m_axis_tuser); errors++;
                    end
                    if (m_axis_tlast !== e.rlast) begin
                        $error("run_last exp %b got %b", e.rlast, m_axis_tlast); errors++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) predict_bundles(driven_cmd);
            // watchdog on transfers of either side
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else if (++idle_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ---------------- driver: change inputs at falling edge ----------------
    int send_wait = 0;
    int recv_wait = 0;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!(s_axis_tvalid && !took_in)) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    driven_cmd = pending_cmds.pop_front();
                    s_axis_tdata <= pack_cmd(driven_cmd);
                    s_axis_tvalid <= 1'b1;
                    send_wait = draw_wait();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            if (took_out) recv_wait = draw_wait();
            if (recv_wait > 0) begin
                recv_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic add_slot(int b, int s, logic [28:0] id, logic en);
        cmd_t c = '{default: '0};
        c.kind = KIND_SLOT; c.bidx = 2'(b); c.sidx = 3'(s); c.id = id; c.en = en;
        c.payload = {$urandom, $urandom};
        pending_cmds = {pending_cmds, c};
    endtask

    task automatic add_settings(int b, logic [1:0] m, logic [15:0] w,
                                logic [7:0] src, logic [7:0] typ);
        cmd_t c = '{default: '0};
        c.kind = KIND_SET; c.bidx = 2'(b); c.mode = m; c.win = w; c.src = src; c.typ = typ;
        c.t = 48'({$urandom, $urandom});
        pending_cmds = {pending_cmds, c};
    endtask

    task automatic add_frame(logic [28:0] id, logic [3:0] len, logic [63:0] pay,
                             logic [47:0] t);
        cmd_t c = '{default: '0};
        c.kind = KIND_FRAME; c.id = id; c.len = len; c.payload = pay; c.t = t;
        c.sidx = 3'($urandom); c.bidx = 2'($urandom); c.mode = 2'($urandom);
        c.win = 16'($urandom);
        pending_cmds = {pending_cmds, c};
    endtask

    task automatic add_nothing();
        cmd_t c;
        c.kind = KIND_NONE; c.bidx = 2'($urandom); c.sidx = 3'($urandom);
        c.id = 29'($urandom); c.en = 1'($urandom); c.mode = 2'($urandom);
        c.win = 16'($urandom); c.src = 8'($urandom); c.typ = 8'($urandom);
        c.len = 4'($urandom); c.payload = {$urandom, $urandom};
        c.t = 48'({$urandom, $urandom});
        pending_cmds = {pending_cmds, c};
    endtask

    // Sender holds off until every expected bundle frame is out, then the block settles.
    task automatic drain();
        while (pending_cmds.size() > 0 || s_axis_tvalid || bundle_queue.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_gap(logic [31:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        gap_us = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [28:0] pool[6];
        logic [47:0] now;
        logic [28:0] fid;
        logic [3:0]  flen;
        gap_us = GAP_RESET;
        for (int k = 0; k < NB*NS; k++) begin
            tbl_id[k] = '0; tbl_used[k] = 0; tbl_rx[k] = 0;
            tbl_pay[k] = '0; tbl_len[k] = '0;
        end
        for (int b = 0; b < NB; b++) begin
            b_mode[b] = MODE_OFF; b_win[b] = '0; b_src[b] = '0; b_typ[b] = '0;
            b_start[b] = '0; b_run[b] = 0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: one bundler per mode, extreme ids, lengths and windows
        add_settings(0, MODE_ALL, 16'hFFFF, 8'hFF, 8'h00);
        add_slot(0, 0, 29'h0, 1);
        add_slot(0, 7, 29'h1FFFFFFF, 1);
        add_settings(1, MODE_TIMED, 16'h0, 8'h00, 8'hFF);
        add_slot(1, 3, 29'h1FFFFFFF, 1);
        add_settings(2, MODE_SAMPLE, 16'hFFFF, 8'hA5, 8'h5A);
        add_slot(2, 0, 29'h0, 1);
        add_slot(3, 0, 29'h0, 1);              // bundler 3 stays inactive
        add_frame(29'h0, 4'd0, 64'h0, 48'd100);
        add_frame(29'h1FFFFFFF, 4'd15, '1, 48'd150);   // completes bundler 0
        add_frame(29'h1FFFFFFF, 4'd8, 64'h0123456789ABCDEF, 48'd152); // timed exceeds 0 ms
        add_frame(29'h0, 4'd8, '1, 48'd90);            // time going backwards
        add_frame(29'h0, 4'd3, 64'h55, 48'd5000);
        add_frame(29'h1FFFFFFF, 4'd1, 64'h1, 48'd7000); // gap timeout drops bundle
        add_nothing();
        add_frame(29'h0, 4'd2, 64'h2, 48'd65535100);   // sample window reached exactly, not yet passed
        add_frame(29'h0, 4'd2, 64'h3, 48'hFFFFFFFFFFFF);
        add_slot(0, 7, 29'h1FFFFFFF, 0);               // disable slot: single-slot bundle
        add_frame(29'h0, 4'd4, 64'h4, 48'hFFFFFFFFFFFF);
        drain();

        // random phases, each under its own gap timeout
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_gap(32'd0);
                1: write_gap(32'hFFFFFFFF);
                2: write_gap(GAP_RESET);
                default: write_gap($urandom_range(0, 8000));
            endcase
            quiet = (ph % 3 == 1);
            foreach (pool[i]) pool[i] = 29'($urandom);
            for (int b = 0; b < NB; b++) begin
                add_settings(b,
                             ($urandom_range(0, 5) == 0) ? MODE_OFF : 2'($urandom_range(0, 2)),
                             ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 3)),
                             8'($urandom), 8'($urandom));
                for (int s = 0; s < NS; s++)
                    if ($urandom_range(0, 2) != 0)
                        add_slot(b, s, pool[$urandom_range(0, 5)], $urandom_range(0, 4) != 0);
            end
            now = {16'($urandom_range(0, 16'hFFF0)), $urandom};
            for (int n = 0; n < 30; n++) begin
                case ($urandom_range(0, 2))
                    0: now += $urandom_range(0, 50);
                    1: now += $urandom_range(0, 3000);
                    default: now += $urandom_range(0, 20000);
                endcase
                fid = ($urandom_range(0, 6) == 0) ? 29'($urandom) : pool[$urandom_range(0, 5)];
                flen = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 8));
                case ($urandom_range(0, 19))
                    0: add_nothing();
                    1: add_slot($urandom_range(0, NB-1), $urandom_range(0, NS-1),
                                pool[$urandom_range(0, 5)], 1'($urandom));
                    2: add_frame(fid, flen, {$urandom, $urandom}, now - $urandom_range(0, 5000));
                    default: add_frame(fid, flen, {$urandom, $urandom}, now);
                endcase
            end
            drain();
        end

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
